@@ rtl/core/tvc_pkg.sv @@
// Shared types, codes and field widths of the tea vending controller.
`default_nettype none
package tvc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int COIN_VALUE_DEF  = 25;

    localparam int REQ_W    = 4;
    localparam int AMT_W    = 16;
    localparam int PRICE_W  = 16;
    localparam int CREDIT_W = 16;
    localparam int STOCK_W  = 16;
    localparam int ACT_W    = 3;
    localparam int MODE_W   = 3;
    localparam int SEL_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_COIN         = 4'd0,
        REQ_SMALL        = 4'd1,
        REQ_LARGE        = 4'd2,
        REQ_SUGAR        = 4'd3,
        REQ_TEA          = 4'd4,
        REQ_REFILL_LARGE = 4'd5,
        REQ_REFILL_SMALL = 4'd6,
        REQ_CANCEL       = 4'd7,
        REQ_SHUTDOWN     = 4'd8
    } req_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE         = 3'd0,
        ACT_RETURN_COIN  = 3'd1,
        ACT_RETURN_COINS = 3'd2,
        ACT_SMALL        = 3'd3,
        ACT_SMALL_SUGAR  = 3'd4,
        ACT_LARGE        = 3'd5,
        ACT_LARGE_SUGAR  = 3'd6,
        ACT_SHUTDOWN     = 3'd7
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE     = 3'd0,
        MODE_PAID     = 3'd1,
        MODE_SUGAR    = 3'd2,
        MODE_NO_SMALL = 3'd3,
        MODE_NO_LARGE = 3'd4,
        MODE_OFF      = 3'd5
    } mode_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_NONE  = 2'd0,
        SEL_LARGE = 2'd1,
        SEL_SMALL = 2'd2
    } sel_t;

    // Outcome of one event: flag, action and the control state after it.
    typedef struct packed {
        logic    accepted;
        action_t action;
        mode_t   mode;
        sel_t    sel;
    } evt_res_t;

endpackage
`default_nettype wire

@@ rtl/core/tvc_in_reg.sv @@
// Input register: holds one accepted event word until the event logic takes it.
`default_nettype none
module tvc_in_reg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [tvc_pkg::REQ_W-1:0] req_type,
    input  wire logic [tvc_pkg::AMT_W-1:0] cup_amount,
    input  wire logic                      advance,
    output logic                           ev_valid,
    output logic [tvc_pkg::REQ_W-1:0]      ev_req,
    output logic [tvc_pkg::AMT_W-1:0]      ev_amt
);
    import tvc_pkg::*;

    logic               valid_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic               load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_type;
            amt_reg <= cup_amount;
        end
    end

    assign ev_valid = valid_reg;
    assign ev_req   = req_reg;
    assign ev_amt   = amt_reg;

endmodule
`default_nettype wire

@@ rtl/core/tvc_event_logic.sv @@
// Next-state logic: decodes one event against the current state.
`default_nettype none
module tvc_event_logic #(
    parameter int COUNT_WIDTH = tvc_pkg::COUNT_WIDTH_DEF,
    parameter int COIN_VALUE  = tvc_pkg::COIN_VALUE_DEF
) (
    input  wire logic [tvc_pkg::REQ_W-1:0]    ev_req,
    input  wire logic [tvc_pkg::AMT_W-1:0]    ev_amt,
    input  wire logic [tvc_pkg::PRICE_W-1:0]  price,
    input  wire tvc_pkg::mode_t               mode,
    input  wire tvc_pkg::sel_t                sel,
    input  wire logic [tvc_pkg::CREDIT_W-1:0] credit,
    input  wire logic [COUNT_WIDTH-1:0]       small_cnt,
    input  wire logic [COUNT_WIDTH-1:0]       large_cnt,
    output tvc_pkg::evt_res_t                 res,
    output logic [tvc_pkg::CREDIT_W-1:0]      credit_next,
    output logic [COUNT_WIDTH-1:0]            small_next,
    output logic [COUNT_WIDTH-1:0]            large_next
);
    import tvc_pkg::*;

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    logic [COUNT_WIDTH-1:0] amt_c;
    logic [CREDIT_W:0]      coin_sum;
    logic [PRICE_W:0]       price_ext;
    logic [COUNT_WIDTH:0]   small_sum;
    logic [COUNT_WIDTH:0]   large_sum;
    logic [COUNT_WIDTH-1:0] small_sat;
    logic [COUNT_WIDTH-1:0] large_sat;
    logic                   paid;
    logic                   sug;
    logic                   amt_nz;

    // refill amount clipped to the counter range
    assign amt_c = (33'(ev_amt) > CNT_MAX) ? '1 : COUNT_WIDTH'(ev_amt);
    assign amt_nz = (ev_amt != '0);

    assign coin_sum  = {1'b0, credit} + (CREDIT_W + 1)'(COIN_VALUE);
    assign price_ext = {1'b0, price};

    assign small_sum = {1'b0, small_cnt} + {1'b0, amt_c};
    assign large_sum = {1'b0, large_cnt} + {1'b0, amt_c};
    assign small_sat = small_sum[COUNT_WIDTH] ? '1 : small_sum[COUNT_WIDTH-1:0];
    assign large_sat = large_sum[COUNT_WIDTH] ? '1 : large_sum[COUNT_WIDTH-1:0];

    assign paid = (mode == MODE_PAID) || (mode == MODE_SUGAR);
    assign sug  = (mode == MODE_SUGAR);

    always_comb
    begin
        res.accepted = 1'b0;
        res.action   = ACT_NONE;
        res.mode     = mode;
        res.sel      = sel;
        credit_next  = credit;
        small_next   = small_cnt;
        large_next   = large_cnt;

        unique case (req_t'(ev_req)) inside
            REQ_COIN:
            begin
                if (mode == MODE_IDLE)
                begin
                    if (coin_sum >= price_ext && price != '0)
                    begin
                        res.sel      = SEL_NONE;
                        credit_next  = '0;
                        res.mode     = MODE_PAID;
                        res.accepted = 1'b1;
                    end
                    else if (coin_sum < price_ext)
                    begin
                        credit_next  = coin_sum[CREDIT_W-1:0];
                        res.accepted = 1'b1;
                    end
                end
                else if (mode != MODE_OFF)
                begin
                    res.accepted = 1'b1;
                    res.action   = ACT_RETURN_COIN;
                end
            end
            REQ_SMALL, REQ_LARGE:
            begin
                if (paid)
                begin
                    res.sel      = (req_t'(ev_req) == REQ_SMALL) ? SEL_SMALL : SEL_LARGE;
                    res.accepted = 1'b1;
                end
            end
            REQ_SUGAR:
            begin
                if (paid)
                begin
                    res.mode     = sug ? MODE_PAID : MODE_SUGAR;
                    res.accepted = 1'b1;
                end
            end
            REQ_TEA:
            begin
                if (paid)
                begin
                    if (sel == SEL_SMALL && small_cnt != '0)
                    begin
                        small_next   = small_cnt - COUNT_WIDTH'(1);
                        res.mode     = (small_cnt == COUNT_WIDTH'(1)) ? MODE_NO_SMALL
                                                                      : MODE_IDLE;
                        res.accepted = 1'b1;
                        res.action   = sug ? ACT_SMALL_SUGAR : ACT_SMALL;
                    end
                    else if (sel == SEL_LARGE && large_cnt != '0)
                    begin
                        large_next   = large_cnt - COUNT_WIDTH'(1);
                        res.mode     = (large_cnt == COUNT_WIDTH'(1)) ? MODE_NO_LARGE
                                                                      : MODE_IDLE;
                        res.accepted = 1'b1;
                        res.action   = sug ? ACT_LARGE_SUGAR : ACT_LARGE;
                    end
                end
            end
            REQ_REFILL_LARGE:
            begin
                if (amt_nz)
                begin
                    if (mode == MODE_IDLE)
                    begin
                        large_next   = large_sat;
                        res.accepted = 1'b1;
                    end
                    else if (mode == MODE_NO_LARGE)
                    begin
                        large_next   = amt_c;
                        res.mode     = MODE_IDLE;
                        res.accepted = 1'b1;
                    end
                end
            end
            REQ_REFILL_SMALL:
            begin
                if (amt_nz)
                begin
                    if (mode == MODE_IDLE)
                    begin
                        small_next   = small_sat;
                        res.accepted = 1'b1;
                    end
                    else if (mode == MODE_NO_SMALL)
                    begin
                        small_next   = amt_c;
                        res.mode     = MODE_IDLE;
                        res.accepted = 1'b1;
                    end
                end
            end
            REQ_CANCEL:
            begin
                if (paid)
                begin
                    res.mode     = MODE_IDLE;
                    res.accepted = 1'b1;
                    res.action   = ACT_RETURN_COINS;
                end
            end
            REQ_SHUTDOWN:
            begin
                if (mode == MODE_IDLE)
                begin
                    res.mode     = MODE_OFF;
                    res.accepted = 1'b1;
                    res.action   = ACT_SHUTDOWN;
                end
            end
            default:
            begin
                // unknown codes: rejected, state kept
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/tvc_out_reg.sv @@
// Result register: holds one result word until the consumer takes it.
`default_nettype none
module tvc_out_reg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    output logic                              free,
    input  wire tvc_pkg::evt_res_t            res,
    input  wire logic [tvc_pkg::CREDIT_W-1:0] credit_in,
    input  wire logic [tvc_pkg::STOCK_W-1:0]  small_in,
    input  wire logic [tvc_pkg::STOCK_W-1:0]  large_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              accepted,
    output logic [tvc_pkg::ACT_W-1:0]         action,
    output logic [tvc_pkg::MODE_W-1:0]        mode_now,
    output logic [tvc_pkg::CREDIT_W-1:0]      credit_now,
    output logic [tvc_pkg::STOCK_W-1:0]       small_stock,
    output logic [tvc_pkg::STOCK_W-1:0]       large_stock,
    output logic [tvc_pkg::SEL_W-1:0]         cup_choice
);
    import tvc_pkg::*;

    logic                valid_reg;
    evt_res_t            res_reg;
    logic [CREDIT_W-1:0] credit_reg;
    logic [STOCK_W-1:0]  small_reg;
    logic [STOCK_W-1:0]  large_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg    <= res;
            credit_reg <= credit_in;
            small_reg  <= small_in;
            large_reg  <= large_in;
        end
    end

    assign out_valid   = valid_reg;
    assign accepted    = res_reg.accepted;
    assign action      = res_reg.action;
    assign mode_now    = res_reg.mode;
    assign credit_now  = credit_reg;
    assign small_stock = small_reg;
    assign large_stock = large_reg;
    assign cup_choice  = res_reg.sel;

endmodule
`default_nettype wire

@@ rtl/core/tea_vending_controller_core.sv @@
// Top level of the tea vending controller: state registers and channel stages.
//
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------------
//  cfg     | cfg_valid / cfg_ready | drink_price
//  in      | in_valid / in_ready   | req_type, cup_amount
//  out     | out_valid / out_ready | accepted, action, mode_now, credit_now,
//          |                       | small_stock, large_stock, cup_choice
//
// One event per cycle while the result side is not stalled; an event is taken into the
// input register, then goes through the event logic into the result register and the state.
// In the state loop, mode, credit, selection and stock registers feed the event
// logic and are written with the result.
// Reset clears the state and the price; cfg_ready is always high.
// A stalled result holds the input register, which then holds in_ready low.
`default_nettype none
module tea_vending_controller_core #(
    parameter int COUNT_WIDTH = tvc_pkg::COUNT_WIDTH_DEF,
    parameter int COIN_VALUE  = tvc_pkg::COIN_VALUE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tvc_pkg::PRICE_W-1:0]  drink_price,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [tvc_pkg::REQ_W-1:0]    req_type,
    input  wire logic [tvc_pkg::AMT_W-1:0]    cup_amount,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              accepted,
    output logic [tvc_pkg::ACT_W-1:0]         action,
    output logic [tvc_pkg::MODE_W-1:0]        mode_now,
    output logic [tvc_pkg::CREDIT_W-1:0]      credit_now,
    output logic [tvc_pkg::STOCK_W-1:0]       small_stock,
    output logic [tvc_pkg::STOCK_W-1:0]       large_stock,
    output logic [tvc_pkg::SEL_W-1:0]         cup_choice
);
    import tvc_pkg::*;

    logic [PRICE_W-1:0]     price_reg;
    mode_t                  mode_reg;
    sel_t                   sel_reg;
    logic [CREDIT_W-1:0]    credit_reg;
    logic [COUNT_WIDTH-1:0] small_reg;
    logic [COUNT_WIDTH-1:0] large_reg;

    evt_res_t               res;
    logic [CREDIT_W-1:0]    credit_next;
    logic [COUNT_WIDTH-1:0] small_next;
    logic [COUNT_WIDTH-1:0] large_next;

    logic                   ev_valid;
    logic [REQ_W-1:0]       ev_req;
    logic [AMT_W-1:0]       ev_amt;
    logic                   out_free;
    logic                   advance;

    assign cfg_ready = 1'b1;
    assign advance   = ev_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            price_reg <= drink_price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            sel_reg    <= SEL_NONE;
            credit_reg <= '0;
            small_reg  <= '0;
            large_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= res.mode;
            sel_reg    <= res.sel;
            credit_reg <= credit_next;
            small_reg  <= small_next;
            large_reg  <= large_next;
        end
    end

    tvc_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .cup_amount (cup_amount),
        .advance    (advance),
        .ev_valid   (ev_valid),
        .ev_req     (ev_req),
        .ev_amt     (ev_amt)
    );

    tvc_event_logic #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .COIN_VALUE  (COIN_VALUE)
    ) u_logic (
        .ev_req      (ev_req),
        .ev_amt      (ev_amt),
        .price       (price_reg),
        .mode        (mode_reg),
        .sel         (sel_reg),
        .credit      (credit_reg),
        .small_cnt   (small_reg),
        .large_cnt   (large_reg),
        .res         (res),
        .credit_next (credit_next),
        .small_next  (small_next),
        .large_next  (large_next)
    );

    tvc_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .free        (out_free),
        .res         (res),
        .credit_in   (credit_next),
        .small_in    (STOCK_W'(small_next)),
        .large_in    (STOCK_W'(large_next)),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .action      (action),
        .mode_now    (mode_now),
        .credit_now  (credit_now),
        .small_stock (small_stock),
        .large_stock (large_stock),
        .cup_choice  (cup_choice)
    );

endmodule
`default_nettype wire

@@ rtl/core/tvc_checker.sv @@
// Port-level checks of the tea vending controller and their bind.
`default_nettype none
module tvc_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [tvc_pkg::PRICE_W-1:0]  drink_price,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [tvc_pkg::REQ_W-1:0]    req_type,
    input  wire logic [tvc_pkg::AMT_W-1:0]    cup_amount,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic                         accepted,
    input  wire logic [tvc_pkg::ACT_W-1:0]    action,
    input  wire logic [tvc_pkg::MODE_W-1:0]   mode_now,
    input  wire logic [tvc_pkg::CREDIT_W-1:0] credit_now,
    input  wire logic [tvc_pkg::STOCK_W-1:0]  small_stock,
    input  wire logic [tvc_pkg::STOCK_W-1:0]  large_stock,
    input  wire logic [tvc_pkg::SEL_W-1:0]    cup_choice
);
    import tvc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(action)
            && $stable(mode_now) && $stable(credit_now) && $stable(small_stock)
            && $stable(large_stock) && $stable(cup_choice))
        else $error("result word changed while stalled");

    a_reject_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> action == ACT_NONE)
        else $error("rejected event carries an action");

    // shut down lasts until reset
    a_off_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == MODE_OFF |=> !out_valid || mode_now == MODE_OFF)
        else $error("left shut down mode");

    a_shutdown_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_SHUTDOWN |-> mode_now == MODE_OFF)
        else $error("shut down action without shut down mode");

    a_serve_choice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_SMALL || action == ACT_SMALL_SUGAR)
            |-> cup_choice == SEL_SMALL && credit_now == '0)
        else $error("small cup served without small selection");

endmodule

bind tea_vending_controller_core tvc_checker u_tvc_checker (.*);
`default_nettype wire

@@ tb/tvc_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the tea vending controller: predicts each result word and compares it.
module tvc_result_checker #(
    parameter int COIN_VALUE = tvc_pkg::COIN_VALUE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [tvc_pkg::PRICE_W-1:0]   drink_price,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [tvc_pkg::REQ_W-1:0]     req_type,
    input  wire logic [tvc_pkg::AMT_W-1:0]     cup_amount,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          accepted,
    input  wire logic [tvc_pkg::ACT_W-1:0]     action,
    input  wire logic [tvc_pkg::MODE_W-1:0]    mode_now,
    input  wire logic [tvc_pkg::CREDIT_W-1:0]  credit_now,
    input  wire logic [tvc_pkg::STOCK_W-1:0]   small_stock,
    input  wire logic [tvc_pkg::STOCK_W-1:0]   large_stock,
    input  wire logic [tvc_pkg::SEL_W-1:0]     cup_choice,
    output int                                 errors,
    output int                                 pending
);
    import tvc_pkg::*;

    typedef struct packed {
        logic                accepted;
        action_t             action;
        mode_t               mode;
        logic [CREDIT_W-1:0] credit;
        logic [STOCK_W-1:0]  small_cups;
        logic [STOCK_W-1:0]  large_cups;
        sel_t                sel;
    } vend_word_t;

    // predicted machine state
    logic [PRICE_W-1:0]  price_q = '0;
    mode_t               mode_q = MODE_IDLE;
    logic [CREDIT_W-1:0] credit_q = '0;
    logic [STOCK_W-1:0]  small_cups_q = '0;
    logic [STOCK_W-1:0]  large_cups_q = '0;
    sel_t                sel_q = SEL_NONE;

    vend_word_t due_words[$];
    vend_word_t want;
    int         words_seen = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 100)
            $display("tvc_result_checker: %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                      words_seen, name, got, exp_val));
    endtask

    // Applies one event to the predicted state and returns the word it yields.
    function automatic vend_word_t vend_response(input logic [REQ_W-1:0] code,
                                                 input logic [AMT_W-1:0] cups);
        vend_word_t            word;
        logic [CREDIT_W:0]     coin_sum;
        logic [STOCK_W:0]      stock_sum;
        logic                  sugared;
        logic                  paid;
        word.accepted = 1'b0;
        word.action   = ACT_NONE;
        sugared       = (mode_q == MODE_SUGAR);
        paid          = (mode_q == MODE_PAID) || sugared;
        coin_sum      = (CREDIT_W + 1)'(credit_q) + (CREDIT_W + 1)'(COIN_VALUE);
        case (code)
            REQ_COIN:
                if (mode_q == MODE_IDLE)
                begin
                    if (price_q != '0 && coin_sum >= price_q)
                    begin
                        credit_q      = '0;
                        sel_q         = SEL_NONE;
                        mode_q        = MODE_PAID;
                        word.accepted = 1'b1;
                    end
                    else if (coin_sum < price_q)
                    begin
                        credit_q      = coin_sum[CREDIT_W-1:0];
                        word.accepted = 1'b1;
                    end
                end
                else if (mode_q != MODE_OFF)
                begin
                    word.accepted = 1'b1;
                    word.action   = ACT_RETURN_COIN;
                end
            REQ_SMALL, REQ_LARGE:
                if (paid)
                begin
                    sel_q         = (code == REQ_SMALL) ? SEL_SMALL : SEL_LARGE;
                    word.accepted = 1'b1;
                end
            REQ_SUGAR:
                if (paid)
                begin
                    mode_q        = sugared ? MODE_PAID : MODE_SUGAR;
                    word.accepted = 1'b1;
                end
            REQ_TEA:
                if (paid && sel_q == SEL_SMALL && small_cups_q != '0)
                begin
                    small_cups_q  = small_cups_q - 1'b1;
                    mode_q        = (small_cups_q == '0) ? MODE_NO_SMALL : MODE_IDLE;
                    word.accepted = 1'b1;
                    word.action   = sugared ? ACT_SMALL_SUGAR : ACT_SMALL;
                end
                else if (paid && sel_q == SEL_LARGE && large_cups_q != '0)
                begin
                    large_cups_q  = large_cups_q - 1'b1;
                    mode_q        = (large_cups_q == '0) ? MODE_NO_LARGE : MODE_IDLE;
                    word.accepted = 1'b1;
                    word.action   = sugared ? ACT_LARGE_SUGAR : ACT_LARGE;
                end
            REQ_REFILL_LARGE:
                if (cups != '0 && mode_q == MODE_IDLE)
                begin
                    stock_sum     = large_cups_q + cups;
                    large_cups_q  = stock_sum[STOCK_W] ? '1 : stock_sum[STOCK_W-1:0];
                    word.accepted = 1'b1;
                end
                else if (cups != '0 && mode_q == MODE_NO_LARGE)
                begin
                    large_cups_q  = cups;
                    mode_q        = MODE_IDLE;
                    word.accepted = 1'b1;
                end
            REQ_REFILL_SMALL:
                if (cups != '0 && mode_q == MODE_IDLE)
                begin
                    stock_sum     = small_cups_q + cups;
                    small_cups_q  = stock_sum[STOCK_W] ? '1 : stock_sum[STOCK_W-1:0];
                    word.accepted = 1'b1;
                end
                else if (cups != '0 && mode_q == MODE_NO_SMALL)
                begin
                    small_cups_q  = cups;
                    mode_q        = MODE_IDLE;
                    word.accepted = 1'b1;
                end
            REQ_CANCEL:
                if (paid)
                begin
                    mode_q        = MODE_IDLE;
                    word.accepted = 1'b1;
                    word.action   = ACT_RETURN_COINS;
                end
            REQ_SHUTDOWN:
                if (mode_q == MODE_IDLE)
                begin
                    mode_q        = MODE_OFF;
                    word.accepted = 1'b1;
                    word.action   = ACT_SHUTDOWN;
                end
            default:
                ;
        endcase
        word.mode       = mode_q;
        word.credit     = credit_q;
        word.small_cups = small_cups_q;
        word.large_cups = large_cups_q;
        word.sel        = sel_q;
        return word;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            price_q      = '0;
            mode_q       = MODE_IDLE;
            credit_q     = '0;
            small_cups_q = '0;
            large_cups_q = '0;
            sel_q        = SEL_NONE;
            due_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                price_q = drink_price;
            // the oldest word is retired before this edge's event is predicted
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                    report_mismatch($sformatf("word %0d arrived with none expected",
                                              words_seen));
                else
                begin
                    want = due_words.pop_front();
                    check_field("accepted", accepted, want.accepted);
                    check_field("action", action, want.action);
                    check_field("mode_now", mode_now, want.mode);
                    check_field("credit_now", credit_now, want.credit);
                    check_field("small_stock", small_stock, want.small_cups);
                    check_field("large_stock", large_stock, want.large_cups);
                    check_field("cup_choice", cup_choice, want.sel);
                end
                words_seen++;
            end
            if (in_valid && in_ready)
                due_words.push_back(vend_response(req_type, cup_amount));
        end
        pending = due_words.size();
    end

endmodule

@@ tb/tb_tea_vending_controller_core.sv @@
`timescale 1ns / 1ps
// Top of the tea vending controller testbench: clock, reset, stimulus and verdict.
module tb_tea_vending_controller_core;
    import tvc_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASES           = 9;
    localparam int EVENTS_PER_PHASE = 150;
    localparam int HOLD_CYCLES      = 60;
    localparam int MAX_COINS        = 10;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED = 4'd15;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PRICE_W-1:0]  drink_price = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [AMT_W-1:0]    cup_amount = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                accepted;
    logic [ACT_W-1:0]    action;
    logic [MODE_W-1:0]   mode_now;
    logic [CREDIT_W-1:0] credit_now;
    logic [STOCK_W-1:0]  small_stock;
    logic [STOCK_W-1:0]  large_stock;
    logic [SEL_W-1:0]    cup_choice;

    int errors;
    int pending;
    int cycle_count = 0;
    int events_sent = 0;
    int price_now = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 50;
    int stall_ask = 0;
    int stall_seen = 0;
    int hold_left = 0;
    bit wide_refill = 1'b0;

    tea_vending_controller_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .drink_price (drink_price),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .cup_amount  (cup_amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .action      (action),
        .mode_now    (mode_now),
        .credit_now  (credit_now),
        .small_stock (small_stock),
        .large_stock (large_stock),
        .cup_choice  (cup_choice)
    );

    tvc_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .drink_price (drink_price),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .cup_amount  (cup_amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .action      (action),
        .mode_now    (mode_now),
        .credit_now  (credit_now),
        .small_stock (small_stock),
        .large_stock (large_stock),
        .cup_choice  (cup_choice),
        .errors      (errors),
        .pending     (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_tea_vending_controller_core: FAIL");
            $finish;
        end
    end

    // Result side: random backpressure, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_seen != stall_ask)
        begin
            stall_seen <= stall_ask;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one event word and returns at the edge that takes it.
    task automatic offer_event(input logic [REQ_W-1:0] code, input logic [AMT_W-1:0] cups);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= code;
        cup_amount <= cups;
        do
            @(posedge clk);
        while (!in_ready);
        events_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_price(input logic [PRICE_W-1:0] value);
        cfg_valid   <= 1'b1;
        drink_price <= value;
        price_now   = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic buy_cup();
        int coins;
        coins = price_now / COIN_VALUE_DEF + 1;
        if (coins > MAX_COINS)
            coins = MAX_COINS;
        if ($urandom_range(3) == 0)
            coins += $urandom_range(2, 1);
        repeat (coins) offer_event(REQ_COIN, AMT_W'($urandom_range(16'hFFFF)));
        // enough credit was offered, so the machine cannot be idle here
        if (price_now != 0 && price_now < MAX_COINS * COIN_VALUE_DEF
            && $urandom_range(11) == 0)
            offer_event(REQ_SHUTDOWN, AMT_W'($urandom_range(16'hFFFF)));
        if ($urandom_range(4) == 0)
            offer_event(REQ_TEA, AMT_W'($urandom_range(16'hFFFF)));
        repeat ($urandom_range(2))
            offer_event(REQ_SUGAR, AMT_W'($urandom_range(16'hFFFF)));
        repeat ($urandom_range(2, 1))
            offer_event($urandom_range(1) ? REQ_SMALL : REQ_LARGE,
                        AMT_W'($urandom_range(16'hFFFF)));
        if ($urandom_range(5) == 0)
            offer_event(REQ_CANCEL, AMT_W'($urandom_range(16'hFFFF)));
        else
            offer_event(REQ_TEA, AMT_W'($urandom_range(16'hFFFF)));
    endtask

    // Small refills keep both stocks running dry now and then.
    task automatic restock();
        int               pick;
        logic [AMT_W-1:0] cups;
        pick = $urandom_range(19);
        if (pick == 0)
            cups = '0;
        else if (wide_refill && pick < 5)
            cups = AMT_W'($urandom_range(16'hFFFF));
        else
            cups = AMT_W'($urandom_range(3, 1));
        offer_event($urandom_range(1) ? REQ_REFILL_SMALL : REQ_REFILL_LARGE, cups);
    endtask

    // Any code but shutdown, unused codes included.
    task automatic noise_event();
        logic [REQ_W-1:0] code;
        code = REQ_W'($urandom_range(REQ_LAST_UNUSED - 1));
        if (code >= REQ_SHUTDOWN)
            code = code + 1'b1;
        offer_event(code, AMT_W'($urandom_range(16'hFFFF)));
    endtask

    initial
    begin
        int               pick;
        int               phase;
        int               phase_end;
        logic [PRICE_W-1:0] price;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero price: coins refused, refills and stray requests in idle
        offer_event(REQ_COIN, 16'hFFFF);
        offer_event(REQ_LAST_UNUSED, 16'hFFFF);
        offer_event(REQ_REFILL_SMALL, '0);
        offer_event(REQ_REFILL_SMALL, 16'd1);
        offer_event(REQ_REFILL_LARGE, 16'd1);
        offer_event(REQ_SMALL, '0);
        offer_event(REQ_TEA, '0);
        offer_event(REQ_CANCEL, '0);
        drain_results();
        load_price(16'd50);
        // partial credit, payment, surplus coin, tea without a cup, last small cup
        offer_event(REQ_COIN, '0);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_TEA, '0);
        offer_event(REQ_SUGAR, '0);
        offer_event(REQ_SMALL, '0);
        offer_event(REQ_TEA, '0);
        // out of small cups: coin returned, shutdown and wrong refill refused
        offer_event(REQ_COIN, '0);
        offer_event(REQ_SHUTDOWN, '0);
        offer_event(REQ_REFILL_LARGE, 16'd3);
        offer_event(REQ_REFILL_SMALL, 16'd2);
        // last large cup, then refill out of that mode
        offer_event(REQ_COIN, '0);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_LARGE, '0);
        offer_event(REQ_TEA, '0);
        offer_event(REQ_REFILL_LARGE, 16'd2);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_CANCEL, '0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:       price = 16'd25;
                1:       price = 16'd50;
                2:       price = 16'hFFFF;
                3:       price = 16'd1;
                4:       price = 16'd60;
                5:       price = 16'd0;
                6:       price = PRICE_W'($urandom_range(MAX_COINS * COIN_VALUE_DEF - 1, 1));
                7:       price = 16'd200;
                default: price = 16'd75;
            endcase
            load_price(price);
            if (phase == 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct <= 27;
            end
            if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                // long hold-off while words keep coming: the core must back up
                stall_ask <= stall_ask + 1;
            end
            wide_refill = (phase == PHASES - 1);
            phase_end = events_sent + EVENTS_PER_PHASE;
            while (events_sent < phase_end)
            begin
                pick = $urandom_range(7);
                if (pick < 5)
                    buy_cup();
                else if (pick < 7)
                    restock();
                else
                    noise_event();
            end
        end

        // back to idle from any mode, saturate both stocks, then shut down
        offer_event(REQ_CANCEL, '0);
        offer_event(REQ_REFILL_SMALL, 16'd1);
        offer_event(REQ_REFILL_LARGE, 16'd1);
        offer_event(REQ_REFILL_SMALL, 16'hFFFF);
        offer_event(REQ_REFILL_SMALL, 16'hFFFF);
        offer_event(REQ_REFILL_LARGE, 16'hFFFF);
        offer_event(REQ_REFILL_LARGE, 16'hFFFF);
        offer_event(REQ_SHUTDOWN, '0);
        offer_event(REQ_COIN, '0);
        offer_event(REQ_REFILL_LARGE, 16'd1);
        offer_event(REQ_SUGAR, '0);
        offer_event(REQ_SHUTDOWN, '0);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_tea_vending_controller_core: PASS");
        else
            $display("tb_tea_vending_controller_core: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tvc_pkg.sv
rtl/core/tvc_in_reg.sv
rtl/core/tvc_event_logic.sv
rtl/core/tvc_out_reg.sv
rtl/core/tea_vending_controller_core.sv
rtl/core/tvc_checker.sv
tb/tvc_result_checker.sv
tb/tb_tea_vending_controller_core.sv
